>>> rtl/assert_macros.svh
// assertion macros for the scanner rtl, used by sts_ctrl
// expects clk_i and rst_ni in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define STS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define STS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define STS_ASSERT(lbl, prop, msg)
`define STS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/sts_pkg.sv
// types, constants and the character font of the seven-segment text scanner
// no dependencies
package sts_pkg;

  localparam int unsigned Digits         = 4;
  localparam int unsigned DefBufDepth    = 256;
  localparam int unsigned DefScrollTicks = 600;
  localparam int unsigned DefBlinkTicks  = 500;
  localparam int unsigned DefMaxLevel    = 20;
  localparam int unsigned CfgAddrW       = 4;
  localparam int unsigned CfgDataW       = 32;
  localparam logic [7:0]  IntensityRst   = 8'd20;

  localparam logic OpTick = 1'b0;
  localparam logic OpLoad = 1'b1;

  typedef enum logic [1:0] {
    ModeFirst  = 2'd0,
    ModeLast   = 2'd1,
    ModeScroll = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    RegMode      = 2'd0,
    RegBlink     = 2'd1,
    RegIntensity = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] char_code;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic [1:0] digit_pos;
    logic [7:0] segments;
  } out_word_t;

  typedef struct packed {
    logic [1:0] display_mode;
    logic [7:0] blink_digit;
    logic [7:0] intensity;
  } cfg_t;

  localparam int unsigned GlyphCount = 41;
  localparam int unsigned GlyphAlpha = 10;
  localparam int unsigned GlyphBlank = 36;
  localparam int unsigned GlyphDash  = 37;
  localparam int unsigned GlyphDot   = 38;
  localparam int unsigned GlyphStar  = 39;
  localparam int unsigned GlyphUnder = 40;

  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiNine  = 8'h39;
  localparam logic [7:0] AsciiUpA   = 8'h41;
  localparam logic [7:0] AsciiUpZ   = 8'h5A;
  localparam logic [7:0] AsciiLoA   = 8'h61;
  localparam logic [7:0] AsciiLoZ   = 8'h7A;
  localparam logic [7:0] AsciiDash  = 8'h2D;
  localparam logic [7:0] AsciiDot   = 8'h2E;
  localparam logic [7:0] AsciiStar  = 8'h2A;
  localparam logic [7:0] AsciiUnder = 8'h5F;

  localparam logic [7:0] Glyphs [GlyphCount] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
    8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h74, 8'h30, 8'h1E,
    8'h76, 8'h38, 8'h00, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
    8'h3E, 8'h3E, 8'h00, 8'h76, 8'h6E, 8'h5B,
    8'h00, 8'h40, 8'h80, 8'h63, 8'h08
  };

  // ascii to segment pattern, blank for anything without a glyph
  function automatic logic [7:0] font_lookup(logic [7:0] c);
    logic [7:0] g;
    if (c >= AsciiZero && c <= AsciiNine) begin
      g = Glyphs[6'(c - AsciiZero)];
    end else if (c >= AsciiUpA && c <= AsciiUpZ) begin
      g = Glyphs[6'(c - AsciiUpA + 8'(GlyphAlpha))];
    end else if (c >= AsciiLoA && c <= AsciiLoZ) begin
      g = Glyphs[6'(c - AsciiLoA + 8'(GlyphAlpha))];
    end else if (c == AsciiDash) begin
      g = Glyphs[GlyphDash];
    end else if (c == AsciiDot) begin
      g = Glyphs[GlyphDot];
    end else if (c == AsciiStar) begin
      g = Glyphs[GlyphStar];
    end else if (c == AsciiUnder) begin
      g = Glyphs[GlyphUnder];
    end else begin
      g = Glyphs[GlyphBlank];
    end
    return g;
  endfunction

endpackage

>>> rtl/sts_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module sts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sts_cfg.sv
// apb register file: display mode, blinking digit and intensity
// depends on sts_pkg
module sts_cfg
  import sts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        RegMode:      cfg_d.display_mode = pwdata[1:0];
        RegBlink:     cfg_d.blink_digit  = pwdata[7:0];
        RegIntensity: cfg_d.intensity    = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegMode:      prdata = CfgDataW'(cfg_q.display_mode);
      RegBlink:     prdata = CfgDataW'(cfg_q.blink_digit);
      RegIntensity: prdata = CfgDataW'(cfg_q.intensity);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{display_mode: 2'd0, blink_digit: 8'd0, intensity: IntensityRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/sts_ctrl.sv
// scan and load control around the pattern store: counters, offset, blink
// depends on sts_pkg, sts_ram and assert_macros.svh
`include "assert_macros.svh"
module sts_ctrl
  import sts_pkg::*;
#(
  parameter int unsigned BufDepth    = DefBufDepth,
  parameter int unsigned ScrollTicks = DefScrollTicks,
  parameter int unsigned BlinkTicks  = DefBlinkTicks,
  parameter int unsigned MaxLevel    = DefMaxLevel
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_word_t  in_i,
  input  cfg_t      cfg_i,
  output logic      res_strobe_o,
  output out_word_t res_o
);

  localparam int unsigned AddrW   = $clog2(BufDepth);
  localparam int unsigned LoadCap = (BufDepth < 255) ? BufDepth : 255;
  localparam int unsigned SlotW   = $clog2(MaxLevel + Digits + 2);

  logic [7:0]       count_q, count_d;
  logic             loading_q, loading_d;
  logic [7:0]       offset_q, offset_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [31:0]      scroll_q, scroll_d;
  logic [31:0]      blink_q, blink_d;
  logic             strobe_q, strobe_d;
  logic [1:0]       dig_q, dig_d;
  logic             show_q, show_d;

  logic [7:0]       level;
  logic [SlotW-1:0] last_slot, slot_eff;
  logic             scrolling, over, in_digit, blink_off, room, we;
  logic [8:0]       off_inc, idx;
  logic [7:0]       off_new, base, cnt;
  logic [7:0]       pattern, rdata;

  // tick path
  always_comb begin
    level       = (cfg_i.intensity > 8'(MaxLevel)) ? 8'(MaxLevel) : cfg_i.intensity;
    last_slot   = SlotW'(MaxLevel + Digits) - SlotW'(level);
    slot_eff    = (slot_q > last_slot) ? '0 : slot_q;
    scrolling   = (cfg_i.display_mode == ModeScroll);
    over        = scroll_q > 32'(ScrollTicks);
    off_inc     = {1'b0, offset_q} + 9'(over);
    off_new     = (off_inc > {1'b0, count_q}) ? 8'd0 : off_inc[7:0];
    case (cfg_i.display_mode)
      ModeScroll: base = off_new;
      ModeLast:   base = (count_q >= 8'(Digits)) ? count_q - 8'(Digits) : 8'd0;
      default:    base = 8'd0;
    endcase
    in_digit  = slot_eff < SlotW'(Digits);
    blink_off = in_digit && (cfg_i.blink_digit == 8'(slot_eff))
                && (blink_q > 32'(BlinkTicks));
    idx       = {1'b0, base} + 9'(slot_eff[1:0]);
  end

  // load path
  always_comb begin
    cnt     = loading_q ? count_q : 8'd0;
    room    = cnt < 8'(LoadCap);
    we      = start_i && (in_i.operation == OpLoad) && room;
    pattern = font_lookup(in_i.char_code);
  end

  always_comb begin
    count_d   = count_q;
    loading_d = loading_q;
    offset_d  = offset_q;
    slot_d    = slot_q;
    scroll_d  = scroll_q;
    blink_d   = blink_q;
    strobe_d  = 1'b0;
    dig_d     = dig_q;
    show_d    = show_q;
    if (start_i) begin
      if (in_i.operation == OpLoad) begin
        if (!loading_q) begin
          offset_d = '0;
          slot_d   = '0;
          scroll_d = '0;
          blink_d  = '0;
        end
        count_d   = room ? cnt + 8'd1 : cnt;
        loading_d = !in_i.last_char;
      end else begin
        slot_d   = slot_eff + SlotW'(1);
        offset_d = scrolling ? off_new : offset_q;
        scroll_d = ((scrolling && over) ? 32'd0 : scroll_q) + 32'd1;
        blink_d  = ((blink_off && (blink_q >= 32'(2 * BlinkTicks))) ? 32'd0 : blink_q)
                   + 32'd1;
        strobe_d = 1'b1;
        dig_d    = in_digit ? slot_eff[1:0] : 2'd0;
        show_d   = in_digit && !blink_off && (idx < {1'b0, count_q});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      loading_q <= 1'b0;
      offset_q  <= '0;
      slot_q    <= '0;
      scroll_q  <= '0;
      blink_q   <= '0;
      strobe_q  <= 1'b0;
    end else begin
      count_q   <= count_d;
      loading_q <= loading_d;
      offset_q  <= offset_d;
      slot_q    <= slot_d;
      scroll_q  <= scroll_d;
      blink_q   <= blink_d;
      strobe_q  <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    show_q <= show_d;
  end

  sts_ram #(
    .Width (8),
    .Depth (BufDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AddrW'(cnt)),
    .wdata_i (pattern),
    .raddr_i (AddrW'(idx)),
    .rdata_o (rdata)
  );

  assign res_strobe_o    = strobe_q;
  assign res_o.digit_pos = dig_q;
  assign res_o.segments  = show_q ? rdata : 8'd0;

  `STS_ASSERT(a_tick_gives_word, (start_i && in_i.operation == OpTick) |=> strobe_q, "tick without result word")
  `STS_ASSERT(a_load_is_silent, (start_i && in_i.operation == OpLoad) |=> !strobe_q, "result word after a load")
  `STS_ASSERT(a_count_capped, count_q <= 8'(LoadCap), "loaded count beyond capacity")
  `STS_ASSERT(a_slot_bounded, slot_q <= SlotW'(MaxLevel + Digits + 1), "scan slot out of range")
  `STS_ASSERT(a_offset_bounded, (start_i && in_i.operation == OpTick && cfg_i.display_mode == ModeScroll) |=> offset_q <= count_q, "scroll offset past text")

endmodule

>>> rtl/seven_segment_text_scanner_core.sv
// seven-segment text scanner, top level
// depends on sts_pkg, sts_cfg, sts_ctrl
//
// Usage
//   input word: taken on a rising edge with start high and busy low. busy is
//   held low, so a word may be given every cycle. A load word stores one
//   character (font pattern) of the text; the first load after a load with
//   last_char set begins a new string and clears the scan, scroll and blink
//   counters. A tick word steps the scan slot.
//   result word: each tick gives one word on res_word_o, valid for the single
//   cycle that res_strobe_o is high; the strobe, the digit and the pattern
//   store read are all registered at the edge that takes the tick. Loads give
//   no result. The receiver has no way to stall; it must take each word in its
//   cycle.
//   throughput: one word per cycle, as the registered read of the pattern
//   store runs alongside the counter update.
//   configuration: apb registers mode (0x0), blink digit (0x4), intensity
//   (0x8); the user must write them only while no tick result is outstanding,
//   unenforced by the block. reset: counters, loading and strobe flags clear,
//   intensity returns to 20; the pattern store is not cleared, no valid text until loaded.
module seven_segment_text_scanner_core
  import sts_pkg::*;
#(
  parameter int unsigned BufDepth    = DefBufDepth,
  parameter int unsigned ScrollTicks = DefScrollTicks,
  parameter int unsigned BlinkTicks  = DefBlinkTicks,
  parameter int unsigned MaxLevel    = DefMaxLevel
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  in_word_t            in_word_i,
  output logic                res_strobe_o,
  output out_word_t           res_word_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  cfg_t cfg;

  assign busy = 1'b0;

  sts_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sts_ctrl #(
    .BufDepth    (BufDepth),
    .ScrollTicks (ScrollTicks),
    .BlinkTicks  (BlinkTicks),
    .MaxLevel    (MaxLevel)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start & ~busy),
    .in_i         (in_word_i),
    .cfg_i        (cfg),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_word_o)
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for seven_segment_text_scanner_core: directed table, then random text
// loads, refresh ticks and register settings checked against a scan predictor; needs sts_pkg
module testbench;
  import sts_pkg::*;

  localparam int unsigned LoadCap       = (DefBufDepth < 255) ? DefBufDepth : 255;
  localparam int unsigned DirCount      = 24;
  localparam int unsigned RandWords     = 300;
  localparam int unsigned WatchdogLimit = 2000;
  localparam logic [1:0]  ModeSpare     = 2'd3;

  localparam logic [7:0] AlnumFont [36] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
    8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h74, 8'h30, 8'h1E,
    8'h76, 8'h38, 8'h00, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
    8'h3E, 8'h3E, 8'h00, 8'h76, 8'h6E, 8'h5B
  };

  typedef struct packed {
    in_word_t  word;
    logic      chk;
    out_word_t exp;
  } dir_row_t;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                start   = 1'b0;
  logic                busy;
  in_word_t            in_word_i = '0;
  logic                res_strobe_o;
  out_word_t           res_word_o;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [CfgAddrW-1:0] paddr   = '0;
  logic [CfgDataW-1:0] pwdata  = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  // typed expectation travelling with a directed word
  logic      dir_chk = 1'b0;
  out_word_t dir_exp = '0;

  // predictor state
  logic [7:0]  glyph_mem [DefBufDepth];
  int unsigned text_len    = 0;
  bit          mid_string  = 1'b0;
  int unsigned scroll_pos  = 0;
  int unsigned slot_idx    = 0;
  int unsigned scroll_cnt  = 0;
  int unsigned blink_cnt   = 0;
  logic [1:0]  cur_mode    = ModeFirst;
  logic [7:0]  cur_blink   = 8'd0;
  logic [7:0]  cur_level   = IntensityRst;

  out_word_t   due_words [$];
  out_word_t   head_word;
  out_word_t   tick_word;
  int unsigned errors      = 0;
  int unsigned words_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  dir_row_t    directed_words [DirCount];

  seven_segment_text_scanner_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_word_i   (in_word_i),
    .res_strobe_o(res_strobe_o),
    .res_word_o  (res_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [7:0] glyph_of(logic [7:0] c);
    logic [7:0] g;
    g = 8'h00;
    if (c >= "0" && c <= "9") begin
      g = AlnumFont[c - "0"];
    end else if (c >= "A" && c <= "Z") begin
      g = AlnumFont[c - "A" + 10];
    end else if (c >= "a" && c <= "z") begin
      g = AlnumFont[c - "a" + 10];
    end else if (c == "-") begin
      g = 8'h40;
    end else if (c == ".") begin
      g = 8'h80;
    end else if (c == "*") begin
      g = 8'h63;
    end else if (c == "_") begin
      g = 8'h08;
    end
    return g;
  endfunction

  function automatic void store_char(in_word_t w);
    if (!mid_string) begin
      text_len   = 0;
      scroll_pos = 0;
      slot_idx   = 0;
      scroll_cnt = 0;
      blink_cnt  = 0;
    end
    if (text_len < LoadCap) begin
      glyph_mem[text_len] = glyph_of(w.char_code);
      text_len++;
    end
    mid_string = !w.last_char;
  endfunction

  function automatic out_word_t scan_tick();
    int unsigned lvl;
    int unsigned top;
    int unsigned base;
    out_word_t   w;
    lvl = (cur_level > DefMaxLevel) ? DefMaxLevel : cur_level;
    top = DefMaxLevel - lvl + Digits;
    if (slot_idx > top) slot_idx = 0;
    case (cur_mode)
      ModeScroll: begin
        if (scroll_cnt > DefScrollTicks) begin
          scroll_pos++;
          scroll_cnt = 0;
        end
        if (scroll_pos > text_len) scroll_pos = 0;
        base = scroll_pos;
      end
      ModeLast: begin
        base = (text_len >= Digits) ? text_len - Digits : 0;
      end
      default: begin
        base = 0;
      end
    endcase
    w = '0;
    if (slot_idx < Digits) begin
      w.digit_pos = slot_idx[1:0];
      if (cur_blink == slot_idx && blink_cnt > DefBlinkTicks) begin
        if (blink_cnt >= 2 * DefBlinkTicks) blink_cnt = 0;
      end else if (base + slot_idx < text_len) begin
        w.segments = glyph_mem[base + slot_idx];
      end
    end
    blink_cnt++;
    scroll_cnt++;
    slot_idx = (slot_idx + 1) & 8'hFF;
    return w;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o === 1'b1) begin
      if (due_words.size() == 0) begin
        $error("word with none due: digit_pos %0d segments %h",
               res_word_o.digit_pos, res_word_o.segments);
        errors++;
      end else begin
        head_word = due_words.pop_front();
        if (res_word_o.digit_pos !== head_word.digit_pos) begin
          $error("digit_pos: expected %0d, got %0d",
                 head_word.digit_pos, res_word_o.digit_pos);
          errors++;
        end
        if (res_word_o.segments !== head_word.segments) begin
          $error("segments: expected %h, got %h", head_word.segments, res_word_o.segments);
          errors++;
        end
      end
    end
    if (rst_ni && start && busy === 1'b0) begin
      if (in_word_i.operation == OpLoad) begin
        store_char(in_word_i);
      end else begin
        tick_word = scan_tick();
        due_words.push_back(dir_chk ? dir_exp : tick_word);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || res_strobe_o === 1'b1 || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_word(in_word_t w, logic chk, out_word_t exp);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    start     <= 1'b1;
    in_word_i <= w;
    dir_chk   <= chk;
    dir_exp   <= exp;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    burst_left--;
    words_sent++;
  endtask

  task automatic send_tick();
    in_word_t w;
    w           = '0;
    w.operation = OpTick;
    w.char_code = 8'($urandom_range(0, 255));
    w.last_char = 1'($urandom_range(0, 1));
    push_word(w, 1'b0, '0);
  endtask

  task automatic send_char(logic [7:0] c, logic last);
    in_word_t w;
    w.operation = OpLoad;
    w.char_code = c;
    w.last_char = last;
    push_word(w, 1'b0, '0);
  endtask

  // wait until every tick word is back and the pipe has emptied
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apb_access(reg_idx_e idx, logic wr, logic [CfgDataW-1:0] wdata,
                            output logic [CfgDataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CfgAddrW'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(reg_idx_e idx, logic [CfgDataW-1:0] exp);
    logic [CfgDataW-1:0] rd;
    apb_access(idx, 1'b0, '0, rd);
    if (rd !== exp) begin
      $error("prdata of %s: expected %h, got %h", idx.name(), exp, rd);
      errors++;
    end
  endtask

  task automatic set_reg(reg_idx_e idx, logic [7:0] val);
    logic [CfgDataW-1:0] rd;
    apb_access(idx, 1'b1, CfgDataW'(val), rd);
    case (idx)
      RegMode: begin
        cur_mode = val[1:0];
        check_reg(idx, CfgDataW'(val[1:0]));
      end
      RegBlink: begin
        cur_blink = val;
        check_reg(idx, CfgDataW'(val));
      end
      default: begin
        cur_level = val;
        check_reg(idx, CfgDataW'(val));
      end
    endcase
  endtask

  task automatic new_settings(bit all);
    logic [1:0] modes [4];
    logic [7:0] v;
    modes = '{ModeFirst, ModeLast, ModeScroll, ModeSpare};
    if (all || $urandom_range(0, 1)) set_reg(RegMode, 8'(modes[$urandom_range(0, 3)]));
    if (all || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 4))
        0: v = 8'hFF;
        1: v = 8'($urandom_range(0, 255));
        default: v = 8'($urandom_range(0, 4));
      endcase
      set_reg(RegBlink, v);
    end
    if (all || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 4))
        0: v = 8'h00;
        1: v = 8'hFF;
        2: v = IntensityRst;
        3: v = 8'($urandom_range(0, 25));
        default: v = 8'($urandom_range(0, 255));
      endcase
      set_reg(RegIntensity, v);
    end
  endtask

  function automatic logic [7:0] pick_char();
    logic [7:0] specials [4];
    logic [7:0] c;
    specials = '{"-", ".", "*", "_"};
    case ($urandom_range(0, 5))
      0: c = 8'("0" + $urandom_range(0, 9));
      1: c = 8'("A" + $urandom_range(0, 25));
      2: c = 8'("a" + $urandom_range(0, 25));
      3: c = specials[$urandom_range(0, 3)];
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // a string, sometimes with ticks inside it or without its closing mark, then a run of ticks
  task automatic text_phase();
    int unsigned len;
    int unsigned ticks;
    bit          closed;
    len    = ($urandom_range(0, 19) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 12);
    closed = ($urandom_range(0, 7) != 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 4) == 0) send_tick();
      send_char(pick_char(), closed && (i == len - 1));
    end
    ticks = $urandom_range(5, 120);
    repeat (ticks) send_tick();
  endtask

  task automatic noise_phase();
    in_word_t w;
    int unsigned n;
    n = $urandom_range(5, 40);
    repeat (n) begin
      w = in_word_t'(10'($urandom_range(0, 1023)));
      push_word(w, 1'b0, '0);
    end
  endtask

  function automatic dir_row_t dir_row(logic op, logic [7:0] c, logic last, logic chk,
                                       logic [1:0] dig, logic [7:0] seg);
    dir_row_t r;
    r.word.operation    = op;
    r.word.char_code    = c;
    r.word.last_char    = last;
    r.chk               = chk;
    r.exp.digit_pos     = dig;
    r.exp.segments      = seg;
    return r;
  endfunction

  initial begin
    int unsigned soak;
    directed_words = '{
      dir_row(OpTick, 8'h00, 1'b0, 1'b1, 2'd0, 8'h00),
      dir_row(OpTick, 8'hFF, 1'b1, 1'b1, 2'd1, 8'h00),
      dir_row(OpTick, 8'h00, 1'b0, 1'b1, 2'd2, 8'h00),
      dir_row(OpTick, 8'h00, 1'b0, 1'b1, 2'd3, 8'h00),
      dir_row(OpTick, 8'h00, 1'b0, 1'b1, 2'd0, 8'h00),
      dir_row(OpLoad, "8",   1'b0, 1'b0, 2'd0, 8'h00),
      dir_row(OpLoad, "a",   1'b0, 1'b0, 2'd0, 8'h00),
      dir_row(OpLoad, "-",   1'b0, 1'b0, 2'd0, 8'h00),
      dir_row(OpLoad, ".",   1'b0, 1'b0, 2'd0, 8'h00),
      dir_row(OpLoad, "*",   1'b0, 1'b0, 2'd0, 8'h00),
      dir_row(OpLoad, "_",   1'b0, 1'b0, 2'd0, 8'h00),
      dir_row(OpLoad, 8'hFF, 1'b0, 1'b0, 2'd0, 8'h00),
      dir_row(OpLoad, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00),
      dir_row(OpLoad, "Z",   1'b0, 1'b0, 2'd0, 8'h00),
      dir_row(OpLoad, "9",   1'b1, 1'b0, 2'd0, 8'h00),
      dir_row(OpTick, 8'h00, 1'b0, 1'b1, 2'd0, 8'h7F),
      dir_row(OpTick, 8'h00, 1'b0, 1'b1, 2'd1, 8'h77),
      dir_row(OpTick, 8'h00, 1'b0, 1'b1, 2'd2, 8'h40),
      dir_row(OpTick, 8'h00, 1'b0, 1'b1, 2'd3, 8'h80),
      dir_row(OpTick, 8'h00, 1'b0, 1'b1, 2'd0, 8'h00),
      dir_row(OpLoad, "7",   1'b1, 1'b0, 2'd0, 8'h00),
      dir_row(OpTick, 8'h00, 1'b0, 1'b1, 2'd0, 8'h07),
      dir_row(OpTick, 8'h00, 1'b0, 1'b1, 2'd1, 8'h00),
      dir_row(OpTick, 8'h00, 1'b0, 1'b1, 2'd2, 8'h00)
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_reg(RegMode, CfgDataW'(ModeFirst));
    check_reg(RegBlink, '0);
    check_reg(RegIntensity, CfgDataW'(IntensityRst));

    foreach (directed_words[i]) begin
      push_word(directed_words[i].word, directed_words[i].chk, directed_words[i].exp);
    end

    settle();
    new_settings(1'b1);
    while (words_sent < DirCount + RandWords) begin
      case ($urandom_range(0, 9))
        0: noise_phase();
        1: begin
          soak = $urandom_range(50, 150);
          repeat (soak) send_tick();
        end
        default: text_phase();
      endcase
      settle();
      new_settings(1'b0);
    end

    // one-character string scrolled out, with the first digit blinking
    set_reg(RegMode, 8'(ModeScroll));
    set_reg(RegBlink, 8'd0);
    set_reg(RegIntensity, 8'd17);
    send_char("H", 1'b1);
    repeat (650) send_tick();

    settle();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
